/* rtl/core/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg - shared types and defaults for the max-heap priority queue
// Operation and status codes, sequencer states and the token control bundle
// passed between the level cells.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Default configuration
    localparam int CAPACITY_DEF    = 1024;
    localparam int KEY_BITS_DEF    = 31;
    localparam int HANDLE_BITS_DEF = 16;

    // Request operation codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FWAIT,
        ST_RUN,
        ST_FIN
    } state_t;

    // Control part of the token handed from one level cell to the next;
    // moved marks an insert token that already placed the new entry and now
    // carries a displaced one
    typedef struct packed {
        logic vld;
        logic moved;
        op_t  op;
    } tok_ctrl_t;

endpackage

/* rtl/core/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue - binary max-heap over a chain of level cells
// Insert walks top-down from the root to the new slot; delete fetches the
// last entry and sifts it down from the root.
// ----------------------------------------------------------------------------
// Insert walks the level cells down to the depth of the new slot; delete
//   walks down to the level where the moved entry settles and skips the
//   walk when it empties the heap; full/empty requests skip the walk.
// Throughput: one request at a time; each level cell holds a token for a
//   memory read, then a compare and write.
// Reset clears the entry count and control state; entry memories need no clear.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_operation,
    input  logic [KEY_BITS-1:0]    s_key_value,
    input  logic [HANDLE_BITS-1:0] s_record_handle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_top_valid,
    output logic [KEY_BITS-1:0]    m_top_key,
    output logic [HANDLE_BITS-1:0] m_top_handle,
    output logic [CW-1:0]          m_entry_count,
    output logic [1:0]             m_status
);

    localparam int PW     = CW + 1;
    localparam int LEVELS = CW;
    localparam int LW     = $clog2(LEVELS);
    localparam int EW     = KEY_BITS + HANDLE_BITS;

    state_t              st_reg,    st_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [LW-1:0]       dep_reg,   dep_next;
    status_t             stat_reg,  stat_next;
    logic [EW-1:0]       root_reg;
    logic                m_vld_reg, m_vld_next;
    logic                m_tv_reg;
    logic [KEY_BITS-1:0] m_key_reg;
    logic [HANDLE_BITS-1:0] m_hdl_reg;
    logic [CW-1:0]       m_cnt_reg;
    status_t             m_stat_reg;

    logic                accept;
    logic                out_load;
    logic [CW-1:0]       lead_in;
    logic [LW-1:0]       lead;
    logic [EW-1:0]       fet;
    tok_ctrl_t           lnch_ctrl;
    logic [PW-1:0]       lnch_pos;
    logic [EW-1:0]       lnch_ent;

    // per-level wiring
    tok_ctrl_t           tout_c [LEVELS];
    logic [PW-1:0]       tout_p [LEVELS];
    logic [EW-1:0]       tout_e [LEVELS];
    logic                peek_v [LEVELS];
    logic [PW-1:0]       peek_p [LEVELS];
    logic [EW-1:0]       rd0    [LEVELS];
    logic [EW-1:0]       rd1    [LEVELS];
    logic                wr_v   [LEVELS];
    logic [EW-1:0]       wr_e   [LEVELS];
    logic [LEVELS-1:0]   done_vec;
    logic [LEVELS-1:0]   fetch_en;

    assign s_ready = (st_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Level of the slot touched by the request
    always_comb begin
        lead_in = (s_operation == OP_INSERT) ? count_reg + CW'(1) : count_reg;
        lead    = '0;
        for (int i = 0; i < CW; i++) begin
            if (lead_in[i]) begin
                lead = LW'(i);
            end
        end
    end

    // Select the fetched last entry from its level
    always_comb begin
        fet = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (dep_reg == LW'(l)) begin
                fet = count_reg[0] ? rd1[l] : rd0[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            fetch_en[l] = (st_reg == ST_FETCH) && (dep_reg == LW'(l));
        end
    end

    // Sequencer: next state, root token launch, result load
    always_comb begin
        st_next         = st_reg;
        count_next      = count_reg;
        dep_next        = dep_reg;
        stat_next       = stat_reg;
        lnch_ctrl.vld   = 1'b0;
        lnch_ctrl.moved = 1'b0;
        lnch_ctrl.op    = OP_INSERT;
        lnch_pos        = PW'(1);
        lnch_ent        = {s_key_value, s_record_handle};
        out_load        = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    stat_next = STAT_DONE;
                    dep_next  = lead;
                    if (s_operation == OP_INSERT) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            stat_next = STAT_FULL;
                            st_next   = ST_FIN;
                        end else begin
                            count_next    = count_reg + CW'(1);
                            lnch_ctrl.vld = 1'b1;
                            st_next       = ST_RUN;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            stat_next = STAT_EMPTY;
                            st_next   = ST_FIN;
                        end else begin
                            st_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                st_next = ST_FWAIT;
            end
            ST_FWAIT: begin
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    st_next = ST_FIN;
                end else begin
                    lnch_ctrl.vld = 1'b1;
                    lnch_ctrl.op  = OP_DELETE;
                    lnch_ent      = fet;
                    st_next       = ST_RUN;
                end
            end
            ST_RUN: begin
                if (|done_vec) begin
                    st_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_vld_reg || m_ready) begin
                    out_load = 1'b1;
                    st_next  = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_vld_next = m_vld_reg;
        if (out_load) begin
            m_vld_next = 1'b1;
        end else if (m_ready) begin
            m_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            count_reg <= '0;
            m_vld_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            count_reg <= count_next;
            m_vld_reg <= m_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        dep_reg  <= dep_next;
        stat_reg <= stat_next;
        if (wr_v[0]) begin
            root_reg <= wr_e[0];
        end
        if (out_load) begin
            m_tv_reg   <= (count_reg != '0);
            m_key_reg  <= (count_reg != '0) ? root_reg[EW-1:HANDLE_BITS] : '0;
            m_hdl_reg  <= (count_reg != '0) ? root_reg[HANDLE_BITS-1:0] : '0;
            m_cnt_reg  <= count_reg;
            m_stat_reg <= stat_reg;
        end
    end

    assign m_valid       = m_vld_reg;
    assign m_top_valid   = m_tv_reg;
    assign m_top_key     = m_key_reg;
    assign m_top_handle  = m_hdl_reg;
    assign m_entry_count = m_cnt_reg;
    assign m_status      = m_stat_reg;

    // Chain of level cells
    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        tok_ctrl_t     tin_c;
        logic [PW-1:0] tin_p;
        logic [EW-1:0] tin_e;
        logic          pin_v;
        logic [PW-1:0] pin_p;
        logic [EW-1:0] lo0;
        logic [EW-1:0] lo1;

        if (g == 0) begin : g_head
            assign tin_c = lnch_ctrl;
            assign tin_p = lnch_pos;
            assign tin_e = lnch_ent;
            assign pin_v = 1'b0;
            assign pin_p = '0;
        end else begin : g_link
            assign tin_c = tout_c[g-1];
            assign tin_p = tout_p[g-1];
            assign tin_e = tout_e[g-1];
            assign pin_v = peek_v[g-1];
            assign pin_p = peek_p[g-1];
        end

        if (g == LEVELS - 1) begin : g_tail
            assign lo0 = '0;
            assign lo1 = '0;
        end else begin : g_below
            assign lo0 = rd0[g+1];
            assign lo1 = rd1[g+1];
        end

        mhpq_cell #(
            .LEVEL       (g),
            .CAPACITY    (CAPACITY),
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS),
            .PW          (PW),
            .CW          (CW),
            .LW          (LW)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .tin_ctrl     (tin_c),
            .tin_pos      (tin_p),
            .tin_ent      (tin_e),
            .tout_ctrl    (tout_c[g]),
            .tout_pos     (tout_p[g]),
            .tout_ent     (tout_e[g]),
            .bc_count     (count_reg),
            .bc_depth     (dep_reg),
            .fetch_en     (fetch_en[g]),
            .fetch_pos    (PW'(count_reg)),
            .peek_in_vld  (pin_v),
            .peek_in_pos  (pin_p),
            .peek_out_vld (peek_v[g]),
            .peek_out_pos (peek_p[g]),
            .rd0_ent      (rd0[g]),
            .rd1_ent      (rd1[g]),
            .lo0_ent      (lo0),
            .lo1_ent      (lo1),
            .wr_en        (wr_v[g]),
            .wr_ent       (wr_e[g]),
            .done         (done_vec[g])
        );
    end

    // Checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_single_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(done_vec))
        else $error("more than one level ended a walk");

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (|done_vec) |-> (st_reg == ST_RUN))
        else $error("walk ended outside of run state");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_FULL)) |-> (m_entry_count == CW'(CAPACITY)))
        else $error("dropped insert reported without full heap");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_EMPTY)) |-> (m_entry_count == '0 && !m_top_valid))
        else $error("ignored delete reported on non-empty heap");

endmodule

/* rtl/core/mhpq_cell.sv */
// ----------------------------------------------------------------------------
// mhpq_cell - one heap level
// Holds every entry of one tree level in two side memories (left and right
// child of a common parent share a row). A token passes a read cycle and then
// a decide cycle here, which writes this level and hands the token on.
// ----------------------------------------------------------------------------
module mhpq_cell
    import mhpq_pkg::*;
#(
    parameter int LEVEL       = 0,
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    parameter int PW          = 12,
    parameter int CW          = 11,
    parameter int LW          = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // token from the level above
    input  tok_ctrl_t                       tin_ctrl,
    input  logic [PW-1:0]                   tin_pos,
    input  logic [KEY_BITS+HANDLE_BITS-1:0] tin_ent,
    // token to the level below
    output tok_ctrl_t                       tout_ctrl,
    output logic [PW-1:0]                   tout_pos,
    output logic [KEY_BITS+HANDLE_BITS-1:0] tout_ent,
    // heap size and depth of the insert slot
    input  logic [CW-1:0]                   bc_count,
    input  logic [LW-1:0]                   bc_depth,
    // direct read of the last entry
    input  logic                            fetch_en,
    input  logic [PW-1:0]                   fetch_pos,
    // child read requested by the level above
    input  logic                            peek_in_vld,
    input  logic [PW-1:0]                   peek_in_pos,
    // child read requested from the level below
    output logic                            peek_out_vld,
    output logic [PW-1:0]                   peek_out_pos,
    // registered read data of this level
    output logic [KEY_BITS+HANDLE_BITS-1:0] rd0_ent,
    output logic [KEY_BITS+HANDLE_BITS-1:0] rd1_ent,
    // read data of the level below
    input  logic [KEY_BITS+HANDLE_BITS-1:0] lo0_ent,
    input  logic [KEY_BITS+HANDLE_BITS-1:0] lo1_ent,
    // write of this level and end of the walk
    output logic                            wr_en,
    output logic [KEY_BITS+HANDLE_BITS-1:0] wr_ent,
    output logic                            done
);

    localparam int EW        = KEY_BITS + HANDLE_BITS;
    localparam int LVL_FIRST = 1 << LEVEL;
    localparam int LVL_LAST  = (CAPACITY < 2 * LVL_FIRST - 1) ? CAPACITY : 2 * LVL_FIRST - 1;
    localparam int ROWS      = (LVL_LAST - LVL_FIRST + 2) / 2;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;

    // side memories: even positions in mem0, odd positions in mem1
    logic [EW-1:0] mem0 [ROWS];
    logic [EW-1:0] mem1 [ROWS];

    logic          tok_vld_reg;
    logic          ph_reg;
    logic          tok_mv_reg;
    op_t           tok_op_reg;
    logic [PW-1:0] tok_pos_reg;
    logic [EW-1:0] tok_ent_reg;
    logic [EW-1:0] rd0_reg;
    logic [EW-1:0] rd1_reg;

    logic [RW-1:0] rd_row;
    logic [RW-1:0] wr_row;
    logic [PW-1:0] c0_pos;
    logic [PW-1:0] c1_pos;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] tgt_sh;
    logic [LW-1:0] sh;
    logic [EW-1:0] node;
    logic [EW-1:0] best;
    logic          leaf;
    logic          v0;
    logic          v1;
    logic          pick0;
    logic          pick1;

    function automatic logic [RW-1:0] row_of(input logic [PW-1:0] pos);
        logic [PW-1:0] half;
        half = pos >> 1;
        return (ROWS > 1) ? half[RW-1:0] : '0;
    endfunction

    // Hold the token for a read cycle and a decide cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_vld_reg <= 1'b0;
            ph_reg      <= 1'b0;
        end else if (tin_ctrl.vld) begin
            tok_vld_reg <= 1'b1;
            ph_reg      <= 1'b0;
        end else if (tok_vld_reg && !ph_reg) begin
            ph_reg      <= 1'b1;
        end else begin
            tok_vld_reg <= 1'b0;
            ph_reg      <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tin_ctrl.vld) begin
            tok_mv_reg  <= tin_ctrl.moved;
            tok_op_reg  <= tin_ctrl.op;
            tok_pos_reg <= tin_pos;
            tok_ent_reg <= tin_ent;
        end
    end

    // Pick the read row: fetch, then child peek, then own token
    always_comb begin
        if (fetch_en) begin
            rd_row = row_of(fetch_pos);
        end else if (peek_in_vld) begin
            rd_row = row_of(peek_in_pos);
        end else begin
            rd_row = row_of(tok_pos_reg);
        end
    end

    assign wr_row = row_of(tok_pos_reg);

    // Level memories, registered read
    always_ff @(posedge aclk) begin
        rd0_reg <= mem0[rd_row];
        rd1_reg <= mem1[rd_row];
        if (wr_en) begin
            if (tok_pos_reg[0]) begin
                mem1[wr_row] <= wr_ent;
            end else begin
                mem0[wr_row] <= wr_ent;
            end
        end
    end

    assign rd0_ent = rd0_reg;
    assign rd1_ent = rd1_reg;

    // For a delete token, request the children row from the level below during the read cycle
    assign c0_pos       = {tok_pos_reg[PW-2:0], 1'b0};
    assign c1_pos       = {tok_pos_reg[PW-2:0], 1'b1};
    assign peek_out_vld = tok_vld_reg && !ph_reg && (tok_op_reg == OP_DELETE);
    assign peek_out_pos = c0_pos;

    assign cnt_ext = PW'(bc_count);
    assign leaf    = (bc_depth == LW'(LEVEL));
    assign sh      = bc_depth - LW'(LEVEL + 1);
    assign tgt_sh  = cnt_ext >> sh;
    assign node    = tok_pos_reg[0] ? rd1_reg : rd0_reg;
    assign v0      = (c0_pos <= cnt_ext);
    assign v1      = (c1_pos <= cnt_ext);

    // Decide cycle: write this level where needed, then pass the token down or end the walk
    always_comb begin
        wr_en           = 1'b0;
        wr_ent          = tok_ent_reg;
        done            = 1'b0;
        tout_ctrl.vld   = 1'b0;
        tout_ctrl.moved = tok_mv_reg;
        tout_ctrl.op    = tok_op_reg;
        tout_pos        = c0_pos;
        tout_ent        = tok_ent_reg;
        best            = tok_ent_reg;
        pick0           = 1'b0;
        pick1           = 1'b0;
        if (tok_vld_reg && ph_reg) begin
            case (tok_op_reg)
                OP_INSERT: begin
                    // follow the path toward the new slot
                    tout_pos = {tok_pos_reg[PW-2:0], tgt_sh[0]};
                    if (leaf) begin
                        wr_en = 1'b1;
                        done  = 1'b1;
                    end else begin
                        tout_ctrl.vld = 1'b1;
                        // place the new entry at a smaller node, then shift the rest down
                        if (tok_mv_reg ||
                            (tok_ent_reg[EW-1:HANDLE_BITS] > node[EW-1:HANDLE_BITS])) begin
                            wr_en           = 1'b1;
                            tout_ent        = node;
                            tout_ctrl.moved = 1'b1;
                        end
                    end
                end
                OP_DELETE: begin
                    // larger child wins, left on a tie, only when strictly greater
                    if (v0 && (lo0_ent[EW-1:HANDLE_BITS] > tok_ent_reg[EW-1:HANDLE_BITS])) begin
                        best  = lo0_ent;
                        pick0 = 1'b1;
                    end
                    if (v1 && (lo1_ent[EW-1:HANDLE_BITS] > best[EW-1:HANDLE_BITS])) begin
                        best  = lo1_ent;
                        pick1 = 1'b1;
                    end
                    wr_en  = 1'b1;
                    wr_ent = best;
                    if (pick0 || pick1) begin
                        tout_ctrl.vld = 1'b1;
                        tout_pos      = pick1 ? c1_pos : c0_pos;
                    end else begin
                        done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
